// File: sv/pwa_pkg.sv
// types and constants shared by the postcode word assembler
`timescale 1ns / 1ps
package pwa_pkg;

	localparam int CODE_W   = 32;
	localparam int WORD_W   = 16;
	localparam int LANE_W   = 4;
	localparam int BYTE_W   = 8;
	localparam int STORED_W = 7;
	localparam int LANE_MAX = 3;

	localparam logic OP_CAPTURE = 1'b0;
	localparam logic OP_READ    = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [WORD_W-1:0] capture_word;
	} item_t;

	typedef struct packed {
		logic                pushed;
		logic                rejected;
		logic [CODE_W-1:0]   new_code;
		logic                read_valid;
		logic [CODE_W-1:0]   read_code;
		logic [STORED_W-1:0] stored_count;
	} result_t;

	typedef struct packed {
		logic              is_read;
		logic              pushed;
		logic              rejected;
		logic [CODE_W-1:0] new_code;
	} cmd_t;

endpackage

// File: sv/pwa_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module pwa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/pwa_front.sv
// front end: takes captured words, assembles groups, emits ring commands
`timescale 1ns / 1ps
module pwa_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid,
	input  pwa_pkg::item_t item,
	input  logic           full,
	output logic           stall,
	output logic           cmd_push,
	output pwa_pkg::cmd_t  cmd
);
	import pwa_pkg::*;

	logic [CODE_W-1:0] code_q;
	logic [LANE_W-1:0] last_q;
	logic              has_q;
	logic [1:0]        bytes_q;
	logic              bad_q;

	logic [LANE_W-1:0] lane;
	logic [BYTE_W-1:0] data;
	logic              close, good;
	logic [CODE_W-1:0] code_b, code_n;
	logic              has_b, bad_b, bad_n, seq_ok;
	logic [LANE_W-1:0] last_b;
	logic [1:0]        bytes_b, bytes_n;
	logic              take;

	assign stall    = full;
	assign take     = valid && !full;
	assign cmd_push = take;

	always_comb begin
		lane  = item.capture_word[BYTE_W +: LANE_W];
		data  = item.capture_word[BYTE_W-1:0];
		close = (lane == '0) && (bytes_q != 2'd0);
		good  = (bytes_q == 2'd2) && !bad_q;

		code_b  = close ? '0 : code_q;
		has_b   = close ? 1'b0 : has_q;
		last_b  = close ? '0 : last_q;
		bytes_b = close ? 2'd0 : bytes_q;
		bad_b   = close ? 1'b0 : bad_q;

		seq_ok  = has_b ? ({1'b0, last_b} + 5'd1 == {1'b0, lane}) : (lane == '0);
		bad_n   = bad_b || !seq_ok || (lane > LANE_W'(LANE_MAX));
		code_n  = code_b;
		if (lane <= LANE_W'(LANE_MAX)) begin
			code_n[lane[1:0]*BYTE_W +: BYTE_W] = data;
		end
		bytes_n = (bytes_b == 2'd2) ? 2'd2 : bytes_b + 2'd1;

		cmd.is_read  = (item.opcode == OP_READ);
		cmd.pushed   = !cmd.is_read && close && good;
		cmd.rejected = !cmd.is_read && close && !good;
		cmd.new_code = (!cmd.is_read && close) ? code_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q  <= '0;
			last_q  <= '0;
			has_q   <= 1'b0;
			bytes_q <= 2'd0;
			bad_q   <= 1'b0;
		end else if (take && item.opcode == OP_CAPTURE) begin
			if (item.capture_word != '0) begin
				code_q  <= code_n;
				last_q  <= lane;
				has_q   <= 1'b1;
				bytes_q <= bytes_n;
				bad_q   <= bad_n;
			end else begin
				code_q  <= code_b;
				last_q  <= last_b;
				has_q   <= has_b;
				bytes_q <= bytes_b;
				bad_q   <= bad_b;
			end
		end
	end

endmodule

// File: sv/pwa_queue.sv
// two-entry command queue between front and back
`timescale 1ns / 1ps
module pwa_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pwa_pkg::cmd_t push_cmd,
	output logic          full,
	output logic          nonempty,
	input  logic          pop,
	output pwa_pkg::cmd_t head
);
	import pwa_pkg::*;

	cmd_t       slot_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign head     = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: sv/pwa_back.sv
// back end: history ring pointers, ring ram access and result register
`timescale 1ns / 1ps
module pwa_back #(
	parameter int RING_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  pwa_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	output logic             valid,
	input  logic             stall,
	output pwa_pkg::result_t result
);
	import pwa_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);

	logic [AW-1:0] wp_q, rp_q, wp_inc, rp_inc;
	logic [CW-1:0] cnt_q, cnt_n;
	logic          advance, do_read, do_write, ring_full;
	logic [CODE_W-1:0] rdata;

	logic                valid_s1, pushed_s1, rejected_s1, read_valid_s1;
	logic [CODE_W-1:0]   new_code_s1;
	logic [STORED_W-1:0] count_s1;

	assign advance   = !valid_s1 || !stall;
	assign cmd_pop   = cmd_valid && advance;
	assign ring_full = (cnt_q == CW'(RING_DEPTH));
	assign do_read   = cmd_pop && cmd.is_read && (cnt_q != '0);
	assign do_write  = cmd_pop && !cmd.is_read && cmd.pushed;
	assign wp_inc    = (wp_q == AW'(RING_DEPTH - 1)) ? '0 : wp_q + AW'(1);
	assign rp_inc    = (rp_q == AW'(RING_DEPTH - 1)) ? '0 : rp_q + AW'(1);

	always_comb begin
		cnt_n = cnt_q;
		if (do_read) begin
			cnt_n = cnt_q - CW'(1);
		end else if (do_write && !ring_full) begin
			cnt_n = cnt_q + CW'(1);
		end
	end

	pwa_ram #(
		.WIDTH(CODE_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (do_write),
		.waddr (wp_q),
		.wdata (cmd.new_code),
		.re    (do_read),
		.raddr (rp_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (do_write) begin
				wp_q <= wp_inc;
			end
			if (do_read || (do_write && ring_full)) begin
				rp_q <= rp_inc;
			end
			cnt_q <= cnt_n;
			if (advance) begin
				valid_s1 <= cmd_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			pushed_s1     <= cmd.pushed;
			rejected_s1   <= cmd.rejected;
			new_code_s1   <= cmd.new_code;
			read_valid_s1 <= do_read;
			count_s1      <= STORED_W'(cnt_n);
		end
	end

	assign valid = valid_s1;

	always_comb begin
		result.pushed       = pushed_s1;
		result.rejected     = rejected_s1;
		result.new_code     = new_code_s1;
		result.read_valid   = read_valid_s1;
		result.read_code    = read_valid_s1 ? rdata : '0;
		result.stored_count = count_s1;
	end

endmodule

// File: sv/postcode_word_assembler_core.sv
// top level of the postcode word assembler with its history ring
//
//   channel   direction   handshake                  payload
//   item      in          item_valid / item_stall    item_t   (opcode, capture_word)
//   result    out         result_valid / result_stall result_t (one per item)
//
// one item per cycle sustained while the queue is not full; a result passes through
// the group logic, the command queue and the ring pointer stage with registered ram read
// reset clears group state, ring pointers and count; ring contents are not cleared
// a stalled result holds; the two-entry queue keeps taking items until it fills
`timescale 1ns / 1ps
module postcode_word_assembler_core #(
	parameter int RING_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  pwa_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output pwa_pkg::result_t result
);
	import pwa_pkg::*;

	logic cmd_push, q_full, q_nonempty, q_pop;
	cmd_t front_cmd, q_head;

	pwa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (item_valid),
		.item     (item),
		.full     (q_full),
		.stall    (item_stall),
		.cmd_push (cmd_push),
		.cmd      (front_cmd)
	);

	pwa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (front_cmd),
		.full     (q_full),
		.nonempty (q_nonempty),
		.pop      (q_pop),
		.head     (q_head)
	);

	pwa_back #(
		.RING_DEPTH(RING_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_nonempty),
		.cmd       (q_head),
		.cmd_pop   (q_pop),
		.valid     (result_valid),
		.stall     (result_stall),
		.result    (result)
	);

endmodule

// File: sim/tb_top.sv
// self-checking testbench for the postcode word assembler core with its history ring
`timescale 1ns / 1ps
module tb_top;
	import pwa_pkg::*;

	localparam int HIST_DEPTH  = 64;
	localparam int BYTES_SAT   = 31;
	localparam int RAND_ITEMS  = 1600;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 20;

	typedef struct packed {
		logic  drain_first;
		item_t it;
	} planned_item_t;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	planned_item_t item_plan[$];
	result_t       due_results[$];
	logic [CODE_W-1:0] code_hist[$];

	logic [CODE_W-1:0] grp_code = '0;
	int   grp_last_lane = -1;
	int   grp_bytes = 0;
	logic grp_bad = 1'b0;

	int   items_taken = 0;
	int   results_seen = 0;
	int   errors = 0;
	int   cycle_cnt = 0;
	int   send_gap;
	int   stall_left;
	logic calm = 1'b0;
	logic drain_next = 1'b0;

	int   n_pushed = 0;
	int   n_rejected = 0;
	int   n_read_hit = 0;
	int   n_read_miss = 0;
	int   n_overflow = 0;
	int   peak_stored = 0;

	postcode_word_assembler_core #(
		.RING_DEPTH(HIST_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// merges one word or serves one read, returns what the block should report
	function automatic result_t assemble_step(item_t it);
		result_t r;
		int lane;
		r = '0;
		if (it.opcode == OP_READ) begin
			if (code_hist.size() > 0) begin
				r.read_valid = 1'b1;
				r.read_code = code_hist.pop_front();
				n_read_hit++;
			end else begin
				n_read_miss++;
			end
		end else begin
			lane = int'(it.capture_word[11:8]);
			// a lane 0 word closes the open group
			if (lane == 0 && grp_bytes > 0) begin
				r.new_code = grp_code;
				if (grp_bytes < 2 || grp_bad) begin
					r.rejected = 1'b1;
					n_rejected++;
				end else begin
					r.pushed = 1'b1;
					n_pushed++;
					if (code_hist.size() == HIST_DEPTH) begin
						code_hist.delete(0);
						n_overflow++;
					end
					code_hist.push_back(grp_code);
				end
				grp_code = '0;
				grp_last_lane = -1;
				grp_bytes = 0;
				grp_bad = 1'b0;
			end
			if (it.capture_word != '0) begin
				if (lane - grp_last_lane != 1)
					grp_bad = 1'b1;
				if (lane > LANE_MAX)
					grp_bad = 1'b1;
				else
					grp_code[lane*BYTE_W +: BYTE_W] = it.capture_word[7:0];
				if (grp_bytes < BYTES_SAT)
					grp_bytes++;
				grp_last_lane = lane;
			end
		end
		r.stored_count = STORED_W'(code_hist.size());
		if (code_hist.size() > peak_stored)
			peak_stored = code_hist.size();
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] word_of(int lane, logic [BYTE_W-1:0] data);
		return {4'($urandom_range(0, 15)), 4'(lane), data};
	endfunction

	task automatic queue_capture(input logic [WORD_W-1:0] w);
		planned_item_t p;
		p.drain_first = drain_next;
		p.it.opcode = OP_CAPTURE;
		p.it.capture_word = w;
		item_plan.push_back(p);
		drain_next = 1'b0;
	endtask

	task automatic queue_read();
		planned_item_t p;
		p.drain_first = drain_next;
		p.it.opcode = OP_READ;
		p.it.capture_word = WORD_W'($urandom_range(0, 65535));
		item_plan.push_back(p);
		drain_next = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [CODE_W-1:0] want,
			input logic [CODE_W-1:0] got);
		if (want !== got) begin
			$display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// sender side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			send_gap = 0;
		end else begin
			if (item_valid && !item_stall) begin
				due_results.push_back(assemble_step(item));
				items_taken++;
			end
			if (!item_valid || !item_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 15) == 0) begin
					send_gap = $urandom_range(0, 9);
					item_valid <= 1'b0;
				end else if (item_plan.size() > 0 &&
						!(item_plan[0].drain_first && items_taken != results_seen)) begin
					item <= item_plan[0].it;
					item_valid <= 1'b1;
					item_plan.delete(0);
				end else begin
					item_valid <= 1'b0;
				end
			end
			calm <= item_plan.size() < 200;
		end
	end

	// receiver side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $time, result);
					errors++;
				end else begin
					check_field("pushed", CODE_W'(due_results[0].pushed),
						CODE_W'(result.pushed));
					check_field("rejected", CODE_W'(due_results[0].rejected),
						CODE_W'(result.rejected));
					check_field("new_code", due_results[0].new_code, result.new_code);
					check_field("read_valid", CODE_W'(due_results[0].read_valid),
						CODE_W'(result.read_valid));
					check_field("read_code", due_results[0].read_code, result.read_code);
					check_field("stored_count", CODE_W'(due_results[0].stored_count),
						CODE_W'(result.stored_count));
					due_results.delete(0);
				end
				results_seen <= results_seen + 1;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				stall_left = $urandom_range(0, 9);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		int start_n;
		int n;
		int lane;
		int read_pct;
		int pick;
		logic [WORD_W-1:0] w;

		// directed part
		queue_read();
		queue_capture(16'h0000);
		queue_capture(16'h0012);
		queue_capture(16'h0134);
		queue_capture(16'h0256);
		queue_capture(16'h03FF);
		queue_capture(16'h0000);
		queue_capture(16'hF000);
		queue_capture(16'hF1FF);
		queue_capture(16'h0000);
		queue_capture(16'h00AB);
		queue_capture(16'h00CD);
		queue_capture(16'h01EF);
		queue_read();
		queue_capture(16'h0011);
		queue_capture(16'h0233);
		queue_capture(16'h0000);
		queue_capture(16'h0044);
		queue_capture(16'h0155);
		queue_capture(16'h0F66);
		queue_capture(16'h0000);
		queue_capture(16'h0177);
		queue_capture(16'h0288);
		queue_capture(16'h0000);
		queue_read();
		queue_read();
		queue_read();

		// random part, alternating fill-heavy and drain-heavy stretches
		start_n = item_plan.size();
		drain_next = 1'b1;
		while (item_plan.size() - start_n < RAND_ITEMS) begin
			if (item_plan.size() - start_n > RAND_ITEMS / 2 && n_overflow == 0) begin
				drain_next = 1'b1;
				n_overflow = -1;
			end
			read_pct = (((item_plan.size() - start_n) / 400) % 2) ? 50 : 5;
			if ($urandom_range(0, 99) < read_pct) begin
				queue_read();
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					n = $urandom_range(2, 4);
					for (int k = 0; k < n; k++) begin
						w = word_of(k, BYTE_W'($urandom_range(0, 255)));
						if (w == '0)
							w[12] = 1'b1;
						queue_capture(w);
						if ($urandom_range(0, 9) == 0)
							queue_read();
					end
					if ($urandom_range(0, 3) == 0)
						queue_capture(16'h0000);
				end else if (pick < 88) begin
					n = $urandom_range(1, 5);
					for (int k = 0; k < n; k++) begin
						lane = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) :
							k + $urandom_range(0, 1);
						queue_capture(word_of(lane, BYTE_W'($urandom_range(0, 255))));
					end
				end else if (pick < 97) begin
					if ($urandom_range(0, 1) == 0)
						queue_capture(16'h0000);
					else
						queue_capture(WORD_W'($urandom_range(0, 65535)));
				end else begin
					// long group that runs the byte count into saturation
					queue_capture(word_of(0, BYTE_W'($urandom_range(1, 255))));
					n = $urandom_range(30, 40);
					for (int k = 0; k < n; k++)
						queue_capture(word_of($urandom_range(1, 15),
							BYTE_W'($urandom_range(0, 255))));
				end
			end
		end
		n_overflow = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(item_plan.size() == 0 && !item_valid && items_taken == results_seen) &&
				cycle_cnt < CYCLE_LIMIT)
			@(negedge clk);

		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				items_taken - results_seen);
			$display("FAILED: results differ");
		end else begin
			repeat (DRAIN_WAIT) @(negedge clk);
			if (due_results.size() != 0) begin
				$display("%0t: %0d expected results never arrived", $time, due_results.size());
				errors += due_results.size();
			end
			$display("run: %0d items, %0d codes stored, %0d groups rejected, %0d ring overflows",
				items_taken, n_pushed, n_rejected, n_overflow);
			$display("run: %0d reads served, %0d reads on empty ring, peak fill %0d, %0d errors",
				n_read_hit, n_read_miss, peak_stored, errors);
			if (errors == 0) begin
				$display("PASSED: all results match");
			end else begin
				$display("FAILED: results differ");
			end
		end
		$finish;
	end

endmodule
